FILE: rtl/dhbd_pkg.sv
// dhbd_pkg: shared types, widths and codes for the detector head box decoder
// used by every rtl file of the block; depends on nothing else
package dhbd_pkg;

  localparam int CMD_W       = 3;
  localparam int VAL_W       = 16;
  localparam int SCORE_W     = 15;
  localparam int DIM_W       = 13;
  localparam int CORNER_W    = 14;
  localparam int CLS_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 15;
  localparam int NUM_W       = 18;
  localparam int PROD_W      = 32;
  localparam int OUT_DATA_W  = 80;

  localparam int NUM_CLASSES_DEF = 80;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CMD_W-1:0] CMD_CX    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CY    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WIDTH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HGT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SCORE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_THRESH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FWIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FHEIGHT = 2'd2;

  localparam logic [SCORE_W-1:0] THRESH_RST = 15'd14746;
  localparam logic [DIM_W-1:0]   DIM_RST    = 13'd640;

  // divide by 20480 = 4096 * 5, the 5 through a reciprocal
  localparam int               DIV_SHIFT   = 12;
  localparam int               RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP     = 19'd419431;
  localparam int               RECIP_SHIFT = 21;

  localparam logic [CORNER_W-1:0] CORNER_MAX = 14'h1fff;
  localparam logic [CORNER_W-1:0] CORNER_MIN = 14'h2000;

  typedef struct packed {
    logic signed [VAL_W-1:0] cx;
    logic signed [VAL_W-1:0] cy;
    logic signed [VAL_W-1:0] w;
    logic signed [VAL_W-1:0] h;
    logic [SCORE_W-1:0]      best;
    logic signed [CLS_W-1:0] cls;
  } anchor_t;

  typedef struct packed {
    logic [DIM_W-1:0] fwidth;
    logic [DIM_W-1:0] fheight;
  } dims_t;

endpackage

FILE: rtl/detector_head_box_decode_top.sv
// detector_head_box_decode_top: detector head output decoder, top level
// front (config, capture, class maximum) -> record queue -> back (corner scaling)
// depends on dhbd_pkg, dhbd_front, dhbd_queue, dhbd_back
//
//   group  dir  payload
//   in_    in   tuser command, tdata value, tlast last of anchor
//   out_   out  tdata corners, best score, class index
//   cfg_   in   index 0 threshold, 1 frame width, 2 frame height
//
// one input transaction per cycle while in_tready is high; passing anchors give output
// the four-entry record queue absorbs output stalls, in_tready drops only when it is full
// output pipeline: four 18x14 multipliers, then reciprocal divide by 20480 and saturation
// rst_n is synchronous; no clearing pass after reset
module detector_head_box_decode_top #(
  parameter int NUM_CLASSES = dhbd_pkg::NUM_CLASSES_DEF,
  parameter int QUEUE_DEPTH = dhbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [dhbd_pkg::VAL_W-1:0]   in_tdata,   // [15:0] value
  input  logic [dhbd_pkg::CMD_W-1:0]          in_tuser,   // [2:0] command
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [13:0] box_left, [27:14] box_top, [41:28] box_right, [55:42] box_bottom,
  // [70:56] best_score, [78:71] class_index, [79] zero
  output logic [dhbd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dhbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dhbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic              q_full, q_not_empty, push, pop;
  dhbd_pkg::anchor_t push_data, head;
  dhbd_pkg::dims_t   dims;

  dhbd_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data),
    .dims      (dims)
  );

  dhbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  dhbd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .dims        (dims),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

FILE: rtl/dhbd_front.sv
// dhbd_front: configuration registers, box value capture and running class maximum
// pushes one anchor record per closed anchor that passes the threshold; uses dhbd_pkg
module dhbd_front #(
  parameter int NUM_CLASSES = dhbd_pkg::NUM_CLASSES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic signed [dhbd_pkg::VAL_W-1:0]    in_tdata,
  input  logic [dhbd_pkg::CMD_W-1:0]           in_tuser,
  input  logic                                 in_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dhbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dhbd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 q_full,
  output logic                                 push,
  output dhbd_pkg::anchor_t                    push_data,
  output dhbd_pkg::dims_t                      dims
);

  localparam int CNT_W = $clog2(NUM_CLASSES + 1);

  logic [dhbd_pkg::SCORE_W-1:0] thresh_r;
  logic [dhbd_pkg::DIM_W-1:0]   fwidth_r, fheight_r;
  logic signed [dhbd_pkg::VAL_W-1:0] cx_r, cy_r, w_r, h_r;
  logic [dhbd_pkg::SCORE_W-1:0] best_r, best_nxt;
  logic signed [dhbd_pkg::CLS_W-1:0] cls_r, cls_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic accept, is_score, take, gt, close;
  logic [dhbd_pkg::SCORE_W-1:0] best_upd;
  logic signed [dhbd_pkg::CLS_W-1:0] cls_upd;

  assign in_tready = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_tvalid && in_tready;
  assign is_score  = accept && (in_tuser == dhbd_pkg::CMD_SCORE);
  assign take      = cnt_r < CNT_W'(NUM_CLASSES);
  assign gt        = take && !in_tdata[dhbd_pkg::VAL_W-1]
                     && (in_tdata[dhbd_pkg::SCORE_W-1:0] > best_r);
  assign best_upd  = gt ? in_tdata[dhbd_pkg::SCORE_W-1:0] : best_r;
  assign cls_upd   = gt ? dhbd_pkg::CLS_W'(cnt_r) : cls_r;
  assign close     = is_score && in_tlast;

  always_comb begin
    best_nxt = best_r;
    cls_nxt  = cls_r;
    cnt_nxt  = cnt_r;
    if (close) begin
      best_nxt = '0;
      cls_nxt  = '1;
      cnt_nxt  = '0;
    end else if (is_score) begin
      best_nxt = best_upd;
      cls_nxt  = cls_upd;
      if (take) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  assign push           = close && (best_upd >= thresh_r);
  assign push_data.cx   = cx_r;
  assign push_data.cy   = cy_r;
  assign push_data.w    = w_r;
  assign push_data.h    = h_r;
  assign push_data.best = best_upd;
  assign push_data.cls  = cls_upd;
  assign dims.fwidth    = fwidth_r;
  assign dims.fheight   = fheight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= dhbd_pkg::THRESH_RST;
      fwidth_r  <= dhbd_pkg::DIM_RST;
      fheight_r <= dhbd_pkg::DIM_RST;
      cx_r      <= '0;
      cy_r      <= '0;
      w_r       <= '0;
      h_r       <= '0;
      best_r    <= '0;
      cls_r     <= '1;
      cnt_r     <= '0;
    end else begin
      best_r <= best_nxt;
      cls_r  <= cls_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dhbd_pkg::REG_THRESH:  thresh_r  <= cfg_data;
          dhbd_pkg::REG_FWIDTH:  fwidth_r  <= cfg_data[dhbd_pkg::DIM_W-1:0];
          dhbd_pkg::REG_FHEIGHT: fheight_r <= cfg_data[dhbd_pkg::DIM_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        case (in_tuser)
          dhbd_pkg::CMD_CX:    cx_r <= in_tdata;
          dhbd_pkg::CMD_CY:    cy_r <= in_tdata;
          dhbd_pkg::CMD_WIDTH: w_r  <= in_tdata;
          dhbd_pkg::CMD_HGT:   h_r  <= in_tdata;
          default: ;
        endcase
      end
    end
  end

  a_push_above_thresh: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_data.best >= thresh_r))
    else $error("record pushed below threshold");

  a_class_has_score: assert property (@(posedge clk) disable iff (!rst_n)
    (cls_r != '1) |-> (best_r != '0))
    else $error("running class set without positive score");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NUM_CLASSES))
    else $error("class counter past class count");

endmodule

FILE: rtl/dhbd_queue.sv
// dhbd_queue: small flip-flop fifo of anchor records between front and back
// uses dhbd_pkg for the record type
module dhbd_queue #(
  parameter int DEPTH = dhbd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dhbd_pkg::anchor_t  push_data,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output dhbd_pkg::anchor_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  dhbd_pkg::anchor_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_pop;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_r == rd_r))
    else $error("empty queue with pointers apart");

endmodule

FILE: rtl/dhbd_back.sv
// dhbd_back: corner scaling pipeline and output register
// multiply by frame size, divide by 20480 with truncation, saturate; uses dhbd_pkg
module dhbd_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dhbd_pkg::dims_t                       dims,
  input  logic                                  q_not_empty,
  input  dhbd_pkg::anchor_t                     head,
  output logic                                  pop,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [dhbd_pkg::OUT_DATA_W-1:0]       out_tdata
);

  function automatic logic [dhbd_pkg::CORNER_W-1:0] scale_corner(
    input logic signed [dhbd_pkg::PROD_W-1:0] p
  );
    logic [dhbd_pkg::PROD_W-2:0] mag;
    logic [17:0] a;
    logic [36:0] prod;
    logic [15:0] q;
    mag  = p[dhbd_pkg::PROD_W-1] ? 31'(-p) : p[dhbd_pkg::PROD_W-2:0];
    a    = mag[29:dhbd_pkg::DIV_SHIFT];
    prod = 37'(a) * 37'(dhbd_pkg::RECIP);
    q    = prod[36:dhbd_pkg::RECIP_SHIFT];
    if (!p[dhbd_pkg::PROD_W-1]) begin
      scale_corner = (q > 16'(dhbd_pkg::CORNER_MAX)) ? dhbd_pkg::CORNER_MAX
                                                     : q[dhbd_pkg::CORNER_W-1:0];
    end else begin
      scale_corner = (q > 16'd8192) ? dhbd_pkg::CORNER_MIN
                                    : (~q[dhbd_pkg::CORNER_W-1:0] + 14'd1);
    end
  endfunction

  logic adv;
  logic s1_valid_r;
  logic signed [dhbd_pkg::PROD_W-1:0] pl_r, pt_r, pr_r, pb_r;
  logic [dhbd_pkg::SCORE_W-1:0] s1_best_r;
  logic signed [dhbd_pkg::CLS_W-1:0] s1_cls_r;

  logic signed [dhbd_pkg::NUM_W-1:0] cx2, cy2, wx, hy;
  logic signed [dhbd_pkg::NUM_W-1:0] nl, nt, nr, nb;
  logic signed [dhbd_pkg::DIM_W:0] fw_s, fh_s;

  logic out_valid_r;
  logic [dhbd_pkg::CORNER_W-1:0] left_r, top_r, right_r, bottom_r;
  logic [dhbd_pkg::SCORE_W-1:0] best_r;
  logic signed [dhbd_pkg::CLS_W-1:0] cls_r;

  assign adv = !out_valid_r || out_tready;
  assign pop = adv && q_not_empty;

  assign cx2  = {head.cx[dhbd_pkg::VAL_W-1], head.cx, 1'b0};
  assign cy2  = {head.cy[dhbd_pkg::VAL_W-1], head.cy, 1'b0};
  assign wx   = {{2{head.w[dhbd_pkg::VAL_W-1]}}, head.w};
  assign hy   = {{2{head.h[dhbd_pkg::VAL_W-1]}}, head.h};
  assign nl   = cx2 - wx;
  assign nr   = cx2 + wx;
  assign nt   = cy2 - hy;
  assign nb   = cy2 + hy;
  assign fw_s = {1'b0, dims.fwidth};
  assign fh_s = {1'b0, dims.fheight};

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r      <= dhbd_pkg::PROD_W'(nl) * dhbd_pkg::PROD_W'(fw_s);
      pr_r      <= dhbd_pkg::PROD_W'(nr) * dhbd_pkg::PROD_W'(fw_s);
      pt_r      <= dhbd_pkg::PROD_W'(nt) * dhbd_pkg::PROD_W'(fh_s);
      pb_r      <= dhbd_pkg::PROD_W'(nb) * dhbd_pkg::PROD_W'(fh_s);
      s1_best_r <= head.best;
      s1_cls_r  <= head.cls;
      left_r    <= scale_corner(pl_r);
      top_r     <= scale_corner(pt_r);
      right_r   <= scale_corner(pr_r);
      bottom_r  <= scale_corner(pb_r);
      best_r    <= s1_best_r;
      cls_r     <= s1_cls_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_not_empty;
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, cls_r, best_r, bottom_r, right_r, top_r, left_r};

  a_none_class_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (cls_r == '1)) |-> (best_r == '0))
    else $error("no class but nonzero score");

  a_pop_only_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> s1_valid_r)
    else $error("popped record lost before stage one");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && s1_valid_r) |=> s1_valid_r)
    else $error("stage one dropped during stall");

endmodule
